/* src/cbrf_pkg.sv */
// ----------------------------------------------------------------------------
// cbrf_pkg: shared types and constants for the cubic bisection root finder
// Payload structs, controller/datapath command and status groups, defaults.
// ----------------------------------------------------------------------------
package cbrf_pkg;

	localparam int DataW      = 32;               // Q16.16 operand width
	localparam int AccW       = 64;               // Horner accumulator width
	localparam int EpsW       = 31;               // epsilon register width
	localparam int CountW     = 7;                // halving counter width
	localparam int FracW      = 16;               // fraction bits of Q16.16
	localparam int NumCoef    = 4;
	localparam int StepW      = 2;                // index into the coefficient set
	localparam int MaxIterDef = 48;

	localparam logic [EpsW-1:0] EpsReset = EpsW'(66);
	localparam logic [StepW-1:0] LastStep = StepW'(NumCoef - 1);

	localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
	localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

	typedef struct packed {
		logic signed [DataW-1:0] coef_cubic;
		logic signed [DataW-1:0] coef_square;
		logic signed [DataW-1:0] coef_linear;
		logic signed [DataW-1:0] coef_constant;
		logic signed [DataW-1:0] left_end;
		logic signed [DataW-1:0] right_end;
	} in_item_t;

	typedef struct packed {
		logic signed [DataW-1:0] root;
		logic [CountW-1:0]       halvings;
		logic                    limit_hit;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic             ld_in;       // capture a new request
		logic             start_right; // x := right end, acc := cubic coef
		logic             start_mid;   // x := midpoint, acc := cubic coef
		logic             mul;         // partial products of acc * x
		logic             shf;         // combine, floor by 2^16, saturate
		logic             add;         // saturating add of coefficient
		logic [StepW-1:0] step;        // coefficient used by add
		logic             save_fr;     // keep p(right)
		logic             decide;      // move one end, count the halving
		logic             out_load;    // load the result register
		logic             limit;       // limit flag for the result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic gt_eps;  // right - left > epsilon
		logic at_max;  // halving count reached the limit
	} dp_stat_t;

endpackage

/* src/cbrf_stream_if.sv */
// ----------------------------------------------------------------------------
// cbrf_stream_if: valid/ready channel
// Carries one payload of type T; accepted when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cbrf_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* src/cbrf_datapath.sv */
// ----------------------------------------------------------------------------
// cbrf_datapath: interval registers, Horner unit and result register
// 33x32 and 32x32 partial-product multipliers, 96-bit combine with floor/saturate.
// ----------------------------------------------------------------------------
module cbrf_datapath #(
	parameter int MaxIter = cbrf_pkg::MaxIterDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cbrf_pkg::dp_cmd_t             cmd,
	output cbrf_pkg::dp_stat_t            stat,
	input  cbrf_pkg::in_item_t            in_item,
	input  logic                          cfg_wr_en,
	input  logic [cbrf_pkg::EpsW-1:0]     cfg_wr_data,
	output cbrf_pkg::out_item_t           out_item
);

	localparam int DW = cbrf_pkg::DataW;
	localparam int AW = cbrf_pkg::AccW;
	localparam int FW = cbrf_pkg::FracW;
	localparam int CW = cbrf_pkg::CountW;
	localparam int PW = 3 * DW;               // full product width
	localparam logic [CW-1:0] MaxCount = CW'(MaxIter);

	logic signed [DW-1:0]   coef_q [cbrf_pkg::NumCoef];
	logic signed [DW-1:0]   left_q;
	logic signed [DW-1:0]   right_q;
	logic signed [DW-1:0]   x_q;
	logic signed [AW-1:0]   acc_q;
	logic signed [AW-1:0]   fr_q;
	logic signed [DW+DW:0]  pl_s1;            // low half (unsigned) * x
	logic signed [AW-1:0]   ph_s1;            // high half (signed) * x
	logic signed [AW-1:0]   prod_s2;          // sat64(floor(acc * x / 2^16))
	logic [CW-1:0]          count_q;
	logic [cbrf_pkg::EpsW-1:0] eps_q;
	cbrf_pkg::out_item_t    out_q;

	logic signed [DW:0]     sum_lr;
	logic signed [DW:0]     width;
	logic signed [DW-1:0]   mid;
	logic signed [DW:0]     acc_lo;
	logic signed [DW-1:0]   acc_hi;
	logic signed [PW-1:0]   full_prod;
	logic signed [PW-1:0]   shifted;
	logic [PW-AW:0]         upper;
	logic signed [AW-1:0]   prod_sat;
	logic signed [DW-1:0]   coef_sel;
	logic signed [AW:0]     sum_add;
	logic signed [AW-1:0]   acc_sum;
	logic signed [AW-1:0]   acc_init;
	logic                   same_side;

	// midpoint rounds toward minus infinity
	assign sum_lr = {left_q[DW-1], left_q} + {right_q[DW-1], right_q};
	assign mid    = sum_lr[DW:1];
	assign width  = {right_q[DW-1], right_q} - {left_q[DW-1], left_q};

	assign stat.gt_eps = width > $signed({2'b00, eps_q});
	assign stat.at_max = count_q >= MaxCount;

	assign acc_lo = $signed({1'b0, acc_q[DW-1:0]});
	assign acc_hi = acc_q[AW-1:DW];

	// acc * x = hi * x * 2^32 + lo * x, then floor shift and clamp
	assign full_prod = {ph_s1, {DW{1'b0}}} + {{(PW-DW-DW-1){pl_s1[DW+DW]}}, pl_s1};
	assign shifted   = full_prod >>> FW;
	assign upper     = shifted[PW-1:AW-1];
	assign prod_sat  = ((&upper) || !(|upper)) ? shifted[AW-1:0]
	                 : (shifted[PW-1] ? cbrf_pkg::AccMin : cbrf_pkg::AccMax);

	assign coef_sel = coef_q[cmd.step];
	assign sum_add  = {prod_s2[AW-1], prod_s2} + {{(AW-DW+1){coef_sel[DW-1]}}, coef_sel};
	assign acc_sum  = (sum_add[AW] != sum_add[AW-1])
	                ? (sum_add[AW] ? cbrf_pkg::AccMin : cbrf_pkg::AccMax)
	                : sum_add[AW-1:0];

	assign acc_init  = {{(AW-DW){coef_q[0][DW-1]}}, coef_q[0]};
	assign same_side = (fr_q == '0) || (acc_q == '0) || (fr_q[AW-1] == acc_q[AW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q   <= cbrf_pkg::EpsReset;
			count_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				eps_q <= cfg_wr_data;
			end
			if (cmd.ld_in) begin
				count_q <= '0;
			end else if (cmd.decide) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			coef_q[0] <= in_item.coef_cubic;
			coef_q[1] <= in_item.coef_square;
			coef_q[2] <= in_item.coef_linear;
			coef_q[3] <= in_item.coef_constant;
			left_q    <= in_item.left_end;
			right_q   <= in_item.right_end;
		end
		if (cmd.start_right) begin
			x_q   <= right_q;
			acc_q <= acc_init;
		end else if (cmd.start_mid) begin
			x_q   <= mid;
			acc_q <= acc_init;
		end else if (cmd.add) begin
			acc_q <= acc_sum;
		end
		if (cmd.mul) begin
			pl_s1 <= acc_lo * x_q;
			ph_s1 <= acc_hi * x_q;
		end
		if (cmd.shf) begin
			prod_s2 <= prod_sat;
		end
		if (cmd.save_fr) begin
			fr_q <= acc_q;
		end
		// x_q holds the midpoint, acc_q holds p(mid)
		if (cmd.decide) begin
			if (same_side) begin
				right_q <= x_q;
				fr_q    <= acc_q;
			end else begin
				left_q <= x_q;
			end
		end
		if (cmd.out_load) begin
			out_q.root      <= mid;
			out_q.halvings  <= count_q;
			out_q.limit_hit <= cmd.limit;
		end
	end

	assign out_item = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MaxCount)
		else $error("halving count above limit");
`endif

endmodule

/* src/cbrf_ctrl.sv */
// ----------------------------------------------------------------------------
// cbrf_ctrl: sequencer for the bisection loop
// Runs the width check, Horner steps and end update; owns channel handshakes.
// ----------------------------------------------------------------------------
module cbrf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  cbrf_pkg::dp_stat_t  stat,
	output cbrf_pkg::dp_cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MUL,
		S_SHF,
		S_ADD,
		S_SAVE,
		S_DECIDE,
		S_FINISH
	} state_t;

	state_t                       state_q;
	logic                         out_valid_q;
	logic                         limit_q;
	logic                         fr_valid_q;
	logic                         tgt_mid_q;
	logic [cbrf_pkg::StepW-1:0]   step_q;
	logic                         slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd             = '0;
		cmd.step        = step_q;
		cmd.limit       = limit_q;
		cmd.ld_in       = (state_q == S_IDLE) && in_valid;
		cmd.start_right = (state_q == S_CHECK) && stat.gt_eps && !stat.at_max && !fr_valid_q;
		cmd.start_mid   = (state_q == S_CHECK) && stat.gt_eps && !stat.at_max && fr_valid_q;
		cmd.mul         = (state_q == S_MUL);
		cmd.shf         = (state_q == S_SHF);
		cmd.add         = (state_q == S_ADD);
		cmd.save_fr     = (state_q == S_SAVE);
		cmd.decide      = (state_q == S_DECIDE);
		cmd.out_load    = (state_q == S_FINISH) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			limit_q     <= 1'b0;
			fr_valid_q  <= 1'b0;
			tgt_mid_q   <= 1'b0;
			step_q      <= '0;
		end else begin
			out_valid_q <= (out_valid_q && !out_ready) || cmd.out_load;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						fr_valid_q <= 1'b0;
						state_q    <= S_CHECK;
					end
				end
				S_CHECK: begin
					priority if (!stat.gt_eps) begin
						limit_q <= 1'b0;
						state_q <= S_FINISH;
					end else if (stat.at_max) begin
						limit_q <= 1'b1;
						state_q <= S_FINISH;
					end else begin
						tgt_mid_q <= fr_valid_q;
						step_q    <= cbrf_pkg::StepW'(1);
						state_q   <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_SHF;
				end
				S_SHF: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (step_q == cbrf_pkg::LastStep) begin
						state_q <= tgt_mid_q ? S_DECIDE : S_SAVE;
					end else begin
						step_q  <= step_q + cbrf_pkg::StepW'(1);
						state_q <= S_MUL;
					end
				end
				S_SAVE: begin
					fr_valid_q <= 1'b1;
					state_q    <= S_CHECK;
				end
				S_DECIDE: begin
					state_q <= S_CHECK;
				end
				S_FINISH: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");
	a_decide_fr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> fr_valid_q)
		else $error("end update without p(right)");
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_CHECK && !fr_valid_q))
		else $error("accepted request did not start a width check");
	a_eval_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start_right || cmd.start_mid) |=> (state_q == S_MUL && step_q == 1))
		else $error("evaluation did not start at the first coefficient step");
`endif

endmodule

/* src/cubic_bisection_root_finder_unit.sv */
// ----------------------------------------------------------------------------
// cubic_bisection_root_finder_unit: bisection root search for a cubic
// Halves [left_end, right_end] until no wider than epsilon or at MaxIter.
// ----------------------------------------------------------------------------
//
//   channel  | dir | protocol          | payload
//   ---------+-----+-------------------+--------------------------------------
//   item     | in  | valid/ready       | four coefficients, left/right ends
//   result   | out | valid/ready       | root, halvings, limit_hit
//   cfg      | in  | cfg_wr_en, data   | epsilon (31 bits, reset 66)
//
// Sequence: each halving is one width check, three Horner steps
//   (multiply, floor/saturate, add) and one end update; the 33x32/32x32
//   multiplier pair is used once per Horner step. When h > 0, p(right) is
//   evaluated once before the first halving; h = halvings.
// Reset: arst_n clears the sequencer and the result valid; epsilon goes to 66.
// Stalls: one request at a time; the next request is accepted while the
//   previous result waits in the output register.
//
module cubic_bisection_root_finder_unit #(
	parameter int MaxIter = cbrf_pkg::MaxIterDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	cbrf_stream_if.sink               item,
	cbrf_stream_if.source             result,
	input  logic                      cfg_wr_en,
	input  logic [cbrf_pkg::EpsW-1:0] cfg_wr_data
);

	cbrf_pkg::dp_cmd_t   cmd;    // sequencer commands
	cbrf_pkg::dp_stat_t  stat;   // width/limit status back to the sequencer
	cbrf_pkg::out_item_t res_data;

	// Sequencer: handshakes, loop order, limit flag
	cbrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: interval, Horner evaluation, epsilon and result registers
	cbrf_datapath #(
		.MaxIter (MaxIter)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_item     (item.data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_item    (res_data)
	);

	assign result.data = res_data;

endmodule
